FILE: rtl/gsbt_pkg.sv
package gsbt_pkg;

	typedef enum logic [2:0] {
		REG_WARMUP     = 3'd0,
		REG_WINDOW_END = 3'd1,
		REG_VALID_LIM  = 3'd2,
		REG_AVG_FLOOR  = 3'd3,
		REG_MARGIN     = 3'd4,
		REG_RECAL      = 3'd5
	} reg_idx_t;

	localparam logic [15:0] RST_WARMUP     = 16'd50;
	localparam logic [15:0] RST_WINDOW_END = 16'd300;
	localparam logic [15:0] RST_VALID_LIM  = 16'd200;
	localparam logic [15:0] RST_AVG_FLOOR  = 16'd40;
	localparam logic [7:0]  RST_MARGIN     = 8'd30;
	localparam logic [15:0] RST_RECAL      = 16'd1800;
	localparam logic [15:0] RST_LOWEST     = 16'd200;

	typedef struct packed {
		logic [15:0] warmup_ticks;
		logic [15:0] window_end_tick;
		logic [15:0] valid_limit;
		logic [15:0] average_floor;
		logic [7:0]  offset_margin;
		logic [15:0] recal_period;
	} cfg_t;

	typedef struct packed {
		logic [15:0] num;
		logic [15:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/gas_sensor_baseline_tracker.sv
// Ozone sensor baseline tracker.
// Input channel: in_valid / in_stall with one 16-bit raw sample per tick.
// Output channel: out_valid / out_stall with the corrected sample (17-bit
// signed) and the baseline offset in force after that tick.
// Configuration: APB-style port, six registers at byte addresses 0..20.
// The user must write them only while no transaction is in flight; the
// block does not enforce it. Each item runs the tick counter, window
// tracking and offset update; the division (window average) or modulo
// (recalibration check) goes through a shared bit-serial divider, one
// quotient bit per cycle. An item passes through S_DIV, S_UPD and S_FIN,
// and the result register loads as S_FIN ends; the next item is taken only
// back in S_IDLE, after that load. An in-window sample at or above the
// limit skips the divider and goes from S_IDLE straight to S_FIN.
// A result waits in the output register while out_stall is high; the block
// does not finish the next item until that result has been taken.
// Reset clears the tick counter, sum, count and offset, sets the tracked
// minimum to 200 and the registers to their defaults.
module gas_sensor_baseline_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [16:0] corrected,
	output logic [7:0]         offset_now,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import gsbt_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPD, S_FIN} state_t;

	cfg_t        cfg;
	div_req_t    div_req;
	div_stat_t   div_stat;
	logic        div_start;
	logic [15:0] div_quo;
	logic [15:0] div_rem;

	state_t      state_q;
	logic [15:0] tick_q;
	logic [15:0] sum_q;
	logic [7:0]  count_q;
	logic [15:0] lowest_q;
	logic [7:0]  offset_q;
	logic [15:0] sample_q;
	logic        win_q;
	logic        last_q;
	logic        out_valid_q;
	logic [16:0] corrected_q;
	logic [7:0]  offset_now_q;

	logic        accept;
	logic [15:0] tick_nx;
	logic        in_win;
	logic        smp_ok;
	logic [15:0] sum_nx;
	logic [7:0]  count_nx;
	logic [7:0]  off_fin;
	logic        out_free;

	gsbt_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign tick_nx  = tick_q + 16'd1;
	assign in_win   = (tick_nx > cfg.warmup_ticks) && (tick_nx <= cfg.window_end_tick);
	assign smp_ok   = sample < cfg.valid_limit;
	assign sum_nx   = sum_q + sample;
	assign count_nx = count_q + 8'd1;

	assign div_start   = accept && (!in_win || smp_ok);
	assign div_req.num = in_win ? sum_nx : tick_nx;
	assign div_req.den = in_win ? {8'd0, count_nx} : cfg.recal_period;

	gsbt_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.stat   (div_stat),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	assign off_fin  = ({8'd0, offset_q} >= sample_q) ? {1'b0, offset_q[7:1]} : offset_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tick_q      <= 16'd0;
			sum_q       <= 16'd0;
			count_q     <= 8'd0;
			lowest_q    <= RST_LOWEST;
			offset_q    <= 8'd0;
			win_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_FIN the load below takes over when the output frees up
			if (out_valid_q && !out_stall && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						tick_q <= tick_nx;
						win_q  <= in_win;
						last_q <= (tick_nx == cfg.window_end_tick);
						if (in_win) begin
							if (smp_ok) begin
								sum_q   <= sum_nx;
								count_q <= count_nx;
								state_q <= S_DIV;
							end else begin
								state_q <= S_FIN;
							end
						end else begin
							if (sample < lowest_q)
								lowest_q <= sample;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_stat.done)
						state_q <= S_UPD;
				end
				S_UPD: begin
					if (win_q) begin
						if (div_quo < cfg.valid_limit && div_quo > cfg.average_floor)
							offset_q <= div_quo[7:0] - cfg.offset_margin;
						if (last_q) begin
							sum_q    <= 16'd0;
							count_q  <= 8'd0;
							lowest_q <= cfg.valid_limit;
						end
					end else if (div_rem == 16'd0 && lowest_q < cfg.valid_limit) begin
						offset_q <= lowest_q[7:0] - cfg.offset_margin;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						offset_q    <= off_fin;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			sample_q <= sample;
		if (state_q == S_FIN && out_free) begin
			corrected_q  <= {1'b0, sample_q} - {9'd0, off_fin};
			offset_now_q <= off_fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign corrected  = corrected_q;
	assign offset_now = offset_now_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_neg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && corrected_q[16] |-> &corrected_q[15:7])
		else $error("negative correction below offset range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("accepted transaction did not start processing");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

endmodule

FILE: rtl/gsbt_apb_regs.sv
module gsbt_apb_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output gsbt_pkg::cfg_t   cfg
);
	import gsbt_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warmup_ticks    <= RST_WARMUP;
			cfg_q.window_end_tick <= RST_WINDOW_END;
			cfg_q.valid_limit     <= RST_VALID_LIM;
			cfg_q.average_floor   <= RST_AVG_FLOOR;
			cfg_q.offset_margin   <= RST_MARGIN;
			cfg_q.recal_period    <= RST_RECAL;
		end else if (wr_en) begin
			unique case (idx)
				REG_WARMUP:     cfg_q.warmup_ticks    <= pwdata[15:0];
				REG_WINDOW_END: cfg_q.window_end_tick <= pwdata[15:0];
				REG_VALID_LIM:  cfg_q.valid_limit     <= pwdata[15:0];
				REG_AVG_FLOOR:  cfg_q.average_floor   <= pwdata[15:0];
				REG_MARGIN:     cfg_q.offset_margin   <= pwdata[7:0];
				REG_RECAL:      cfg_q.recal_period    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WARMUP:     prdata = {16'd0, cfg_q.warmup_ticks};
			REG_WINDOW_END: prdata = {16'd0, cfg_q.window_end_tick};
			REG_VALID_LIM:  prdata = {16'd0, cfg_q.valid_limit};
			REG_AVG_FLOOR:  prdata = {16'd0, cfg_q.average_floor};
			REG_MARGIN:     prdata = {24'd0, cfg_q.offset_margin};
			REG_RECAL:      prdata = {16'd0, cfg_q.recal_period};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/gsbt_serdiv.sv
module gsbt_serdiv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  gsbt_pkg::div_req_t  req,
	output gsbt_pkg::div_stat_t stat,
	output logic [15:0]         quo,
	output logic [15:0]         rem
);
	import gsbt_pkg::*;

	// Restoring divider, one quotient bit per cycle. A zero divisor
	// naturally yields an all-ones quotient and the dividend as remainder.
	logic [15:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] part;
	logic [16:0] diff;
	logic        ge;

	assign part = {rem_q, quo_q[15]};
	assign diff = part - {1'b0, den_q};
	assign ge   = !diff[16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 4'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd15;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= req.num;
			rem_q <= 16'd0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[14:0], ge};
			rem_q <= ge ? diff[15:0] : part[15:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;
	assign rem       = rem_q;

endmodule

FILE: sim/gas_sensor_baseline_tracker_tb.sv
module gas_sensor_baseline_tracker_tb;
	import gsbt_pkg::*;

	localparam int HALF_PERIOD = 2;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int REG_COUNT = 6;
	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 60;

	localparam logic [15:0] EDGE_SAMPLES [20] = '{
		16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF, 16'h5555,
		16'hAAAA, 16'd199, 16'd200, 16'd201, 16'd30, 16'd31, 16'd255, 16'd256,
		16'h0000, 16'h0001, 16'h0002, 16'd100, 16'd150
	};

	typedef struct {
		logic signed [16:0] corrected;
		logic [7:0]         offset;
	} tick_result_t;

	class baseline_scoreboard;
		cfg_t         cfg;
		logic [15:0]  tick;
		logic [15:0]  sum;
		logic [7:0]   count;
		logic [15:0]  lowest;
		logic [7:0]   offset;
		tick_result_t expected_q[$];
		int           fails;

		function new();
			cfg = {RST_WARMUP, RST_WINDOW_END, RST_VALID_LIM, RST_AVG_FLOOR,
				RST_MARGIN, RST_RECAL};
			tick = '0;
			sum = '0;
			count = '0;
			lowest = RST_LOWEST;
			offset = '0;
			fails = 0;
		endfunction

		function void set_reg(int idx, logic [31:0] value);
			case (idx)
				REG_WARMUP:     cfg.warmup_ticks = value[15:0];
				REG_WINDOW_END: cfg.window_end_tick = value[15:0];
				REG_VALID_LIM:  cfg.valid_limit = value[15:0];
				REG_AVG_FLOOR:  cfg.average_floor = value[15:0];
				REG_MARGIN:     cfg.offset_margin = value[7:0];
				REG_RECAL:      cfg.recal_period = value[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// one accepted sample = one tick of the tracker
		function void note_sample(logic [15:0] s);
			logic [15:0]  avg;
			logic [15:0]  rem;
			tick_result_t res;
			tick = tick + 16'd1;
			if (tick > cfg.warmup_ticks && tick <= cfg.window_end_tick) begin
				if (s < cfg.valid_limit) begin
					sum = sum + s;
					count = count + 8'd1;
					avg = (count == 8'd0) ? 16'hFFFF : sum / {8'd0, count};
					if (avg < cfg.valid_limit && avg > cfg.average_floor)
						offset = avg[7:0] - cfg.offset_margin;
					if (tick == cfg.window_end_tick) begin
						sum = '0;
						count = '0;
						lowest = cfg.valid_limit;
					end
				end
			end else begin
				if (s < lowest)
					lowest = s;
				rem = (cfg.recal_period == 16'd0) ? tick : tick % cfg.recal_period;
				if (rem == 16'd0 && lowest < cfg.valid_limit)
					offset = lowest[7:0] - cfg.offset_margin;
			end
			if (s <= {8'd0, offset})
				offset = offset >> 1;
			res.corrected = $signed({1'b0, s} - {9'd0, offset});
			res.offset = offset;
			expected_q.push_back(res);
		endfunction

		function void check_result(logic signed [16:0] corrected, logic [7:0] offset_now);
			tick_result_t exp_res;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: corrected %0d offset %0d",
					$time, corrected, offset_now);
				fails++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (corrected !== exp_res.corrected) begin
				$display("%0t: corrected expected %0d, actual %0d",
					$time, exp_res.corrected, corrected);
				fails++;
			end
			if (offset_now !== exp_res.offset) begin
				$display("%0t: offset_now expected %0d, actual %0d",
					$time, exp_res.offset, offset_now);
				fails++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        sample = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [16:0] corrected;
	logic [7:0]         offset_now;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	baseline_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	gas_sensor_baseline_tracker dut (.*);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
		$display("CHECKS FAILED");
		$finish;
	end

	// write, then read back through the same select (back-to-back transfers)
	task automatic write_reg(input int idx, input logic [31:0] value);
		logic [31:0] readback;
		logic [31:0] mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx < REG_COUNT) begin
			sb.set_reg(idx, value);
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
			readback = prdata;
			mask = (idx == REG_MARGIN) ? 32'h0000_00FF : 32'h0000_FFFF;
			if ((readback & mask) !== (value & mask)) begin
				$display("%0t: register %0d read expected %0h, actual %0h",
					$time, idx, value & mask, readback & mask);
				sb.fails++;
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] warm, input logic [15:0] wend,
			input logic [15:0] lim, input logic [15:0] floor_v,
			input logic [7:0] margin, input logic [15:0] period);
		write_reg(REG_WARMUP, {16'd0, warm});
		write_reg(REG_WINDOW_END, {16'd0, wend});
		write_reg(REG_VALID_LIM, {16'd0, lim});
		write_reg(REG_AVG_FLOOR, {16'd0, floor_v});
		write_reg(REG_MARGIN, {24'd0, margin});
		write_reg(REG_RECAL, {16'd0, period});
	endtask

	// entered in a rising-edge time step; returns in the step of acceptance
	task automatic send_sample(input logic [15:0] s, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(s);
	endtask

	function automatic int pick_gap();
		if (quiet || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 8);
	endfunction

	// mostly samples near the limit and the offset, some full range
	function automatic logic [15:0] pick_sample();
		int unsigned span;
		int unsigned r;
		span = (sb.cfg.valid_limit > 16'd400) ? 400 : sb.cfg.valid_limit + 20;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 16'($urandom_range(0, span));
		if (r < 70)
			return 16'($urandom_range(0, sb.offset));
		if (r < 85)
			return 16'($urandom_range(0, 255));
		return 16'($urandom);
	endfunction

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_items(input int n);
		for (int i = 0; i < n; i++)
			send_sample(pick_sample(), pick_gap());
		in_valid <= 1'b0;
		wait_drained();
	endtask

	initial begin : result_monitor
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(corrected, offset_now);
			if (stall_left > 0)
				stall_left--;
			else if (hold_req) begin
				hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (!quiet && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 8);
			out_stall <= (stall_left > 0);
		end
	end

	initial begin : stimulus
		logic [15:0] warm;
		logic [15:0] wend;
		logic [15:0] lim;
		logic [15:0] floor_v;
		logic [7:0]  margin;
		logic [15:0] period;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes at the reset settings
		foreach (EDGE_SAMPLES[i])
			send_sample(EDGE_SAMPLES[i], 0);
		in_valid <= 1'b0;
		wait_drained();

		// margin above the average: offset wraps; recal every tick afterwards
		set_config(sb.tick, sb.tick + 16'd40, 16'd300, 16'd0, 8'd255, 16'd1);
		write_reg(REG_COUNT, 32'hFFFF_FFFF);
		write_reg(REG_COUNT + 1, 32'h0000_0001);
		run_items(PHASE_ITEMS);

		// inverted window, everything tracked as minimum
		set_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 8'd0,
			16'($urandom_range(2, 20)));
		run_items(PHASE_ITEMS);

		// zero recal period: only a wrapped tick counter would fire it
		set_config(sb.tick + 16'd20, sb.tick + 16'd5, 16'd250, 16'd10, 8'd20, 16'd0);
		run_items(40);

		// long window: sample count wraps past 255, sum wraps too
		set_config(sb.tick, sb.tick + 16'd300, 16'hFFFF, 16'd0,
			8'($urandom_range(0, 255)), 16'hFFFF);
		run_items(300);

		// open window but no sample is ever below a zero limit
		set_config(16'd0, 16'hFFFF, 16'd0, 16'd0, 8'($urandom_range(0, 255)), 16'd3);
		run_items(30);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			warm = sb.tick + 16'($urandom_range(0, 30));
			if ($urandom_range(0, 5) == 0)
				wend = warm - 16'($urandom_range(0, 10));
			else
				wend = warm + 16'($urandom_range(1, 60));
			lim = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(50, 400));
			floor_v = 16'($urandom_range(0, 200));
			margin = 8'($urandom_range(0, 255));
			period = 16'($urandom_range(1, 40));
			set_config(warm, wend, lim, floor_v, margin, period);
			quiet = (p >= RANDOM_PHASES - 2);
			if (p == 3)
				hold_req = 1'b1;
			run_items(PHASE_ITEMS);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
